[rtl/core/kehs_pkg.sv]
package kehs_pkg;

    // Timer width and configuration field widths
    localparam int TIMER_BITS   = 16;
    localparam int TIMEOUT_BITS = 16;
    localparam int CMP_BITS     = (TIMER_BITS > TIMEOUT_BITS) ? TIMER_BITS : TIMEOUT_BITS;
    localparam int KEY_BITS     = 32;
    localparam int ADDR_BITS    = 3;

    // Register reset values
    localparam logic [KEY_BITS-1:0]     SERVER_KEY_RESET = '0;
    localparam logic [TIMEOUT_BITS-1:0] TIMEOUT_RESET    = 16'd1000;

    // Register indexes (byte address = 4 * index)
    localparam logic REG_SERVER_KEY = 1'b0;
    localparam logic REG_TIMEOUT    = 1'b1;

    // Protocol characters
    localparam logic [7:0] CHAR_C = 8'h43;
    localparam logic [7:0] CHAR_A = 8'h41;

    // Input transaction modes
    typedef enum logic [1:0] {
        MODE_BYTE    = 2'd0,
        MODE_TICK    = 2'd1,
        MODE_RESTART = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    // Result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Handshake phases
    typedef enum logic [2:0] {
        PH_LISTEN = 3'd0,
        PH_KEY1   = 3'd1,
        PH_ACK1   = 3'd2,
        PH_KEY2   = 3'd3,
        PH_ACK2   = 3'd4,
        PH_DONE   = 3'd5
    } phase_t;

    // Transmit burst: 'A' then four server key bytes
    localparam int          TX_BURST_LEN = 5;
    localparam logic [2:0]  TX_LAST_IDX  = 3'(TX_BURST_LEN - 1);

endpackage

[rtl/core/key_exchange_handshake_server_unit.sv]
// Channel   | Direction | Handshake          | Payload
// ----------+-----------+--------------------+-----------------------------------
// input     | in        | in_valid/in_stall  | mode, rx_byte
// result    | out       | out_valid/out_stall| kind, tx_byte, client_key, last
// config    | in        | APB psel/penable   | paddr, pwdata, prdata (pready = 1)
//
// An input transaction is registered, then updates the handshake state.
// Transactions without results go through at one per cycle.
// A completing 'A' yields one result; the fourth byte of the first key yields five,
// one per cycle from the result register while out_stall is low.
// The next input transaction waits in the input register only if it has results and
// the result register is still busy. rst_n clears state asynchronously to listening.
module key_exchange_handshake_server_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [1:0]                        mode,
    input  logic [7:0]                        rx_byte,
    // result channel
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              kind,
    output logic [7:0]                        tx_byte,
    output logic [kehs_pkg::KEY_BITS-1:0]     client_key,
    output logic                              last,
    // configuration port
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kehs_pkg::ADDR_BITS-1:0]    paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    // Configuration registers
    logic [kehs_pkg::KEY_BITS-1:0]     server_key_reg;
    logic [kehs_pkg::TIMEOUT_BITS-1:0] timeout_reg;
    logic                              cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            server_key_reg <= kehs_pkg::SERVER_KEY_RESET;
            timeout_reg    <= kehs_pkg::TIMEOUT_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == kehs_pkg::REG_SERVER_KEY)
                server_key_reg <= pwdata;
            else
                timeout_reg <= pwdata[kehs_pkg::TIMEOUT_BITS-1:0];
        end
    end

    always_comb
    begin
        if (paddr[2] == kehs_pkg::REG_SERVER_KEY)
            prdata = server_key_reg;
        else
            prdata = 32'(timeout_reg);
    end

    // Input register
    logic        in_valid_reg;
    logic        in_valid_next;
    logic [1:0]  mode_reg;
    logic [7:0]  rx_reg;
    logic        proc_go;
    logic        in_take;

    assign in_stall = in_valid_reg && !proc_go;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            in_valid_next = 1'b1;
        else if (proc_go)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            mode_reg <= mode;
            rx_reg   <= rx_byte;
        end
    end

    // Handshake state
    kehs_pkg::phase_t                    phase_reg, phase_next;
    logic [1:0]                          idx_reg, idx_next;
    logic [kehs_pkg::KEY_BITS-1:0]       key_reg, key_next;
    logic [kehs_pkg::TIMER_BITS-1:0]     timer_reg, timer_next;
    logic [kehs_pkg::TIMER_BITS-1:0]     timer_inc;
    logic                                has_result;
    logic                                burst_load;
    logic                                burst_kind_next;
    logic                                emitter_free;

    // Saturating tick count
    assign timer_inc = (timer_reg == '1) ? timer_reg
                                         : timer_reg + kehs_pkg::TIMER_BITS'(1);

    // Does this transaction produce results
    always_comb
    begin
        has_result = 1'b0;
        if (kehs_pkg::mode_t'(mode_reg) == kehs_pkg::MODE_BYTE)
        begin
            if (phase_reg == kehs_pkg::PH_KEY1 && idx_reg == 2'd3)
                has_result = 1'b1;
            else if ((phase_reg == kehs_pkg::PH_ACK1 || phase_reg == kehs_pkg::PH_ACK2)
                     && rx_reg == kehs_pkg::CHAR_A)
                has_result = 1'b1;
        end
    end

    assign proc_go = in_valid_reg && (!has_result || emitter_free);

    // Next state
    always_comb
    begin
        phase_next      = phase_reg;
        idx_next        = idx_reg;
        key_next        = key_reg;
        timer_next      = timer_reg;
        burst_load      = 1'b0;
        burst_kind_next = kehs_pkg::KIND_TX;
        if (proc_go)
        begin
            unique case (kehs_pkg::mode_t'(mode_reg))
                kehs_pkg::MODE_RESTART:
                begin
                    phase_next = kehs_pkg::PH_LISTEN;
                    idx_next   = '0;
                    key_next   = '0;
                    timer_next = '0;
                end
                kehs_pkg::MODE_TICK:
                begin
                    if (phase_reg != kehs_pkg::PH_LISTEN && phase_reg != kehs_pkg::PH_DONE)
                    begin
                        if (kehs_pkg::CMP_BITS'(timer_inc) >=
                            kehs_pkg::CMP_BITS'(timeout_reg))
                        begin
                            phase_next = kehs_pkg::PH_LISTEN;
                            idx_next   = '0;
                            key_next   = '0;
                            timer_next = '0;
                        end
                        else
                            timer_next = timer_inc;
                    end
                end
                kehs_pkg::MODE_BYTE:
                begin
                    unique case (phase_reg)
                        kehs_pkg::PH_KEY1, kehs_pkg::PH_KEY2:
                        begin
                            key_next = {rx_reg, key_reg[kehs_pkg::KEY_BITS-1:8]};
                            idx_next = idx_reg + 2'd1;
                            if (idx_reg == 2'd3)
                            begin
                                timer_next = '0;
                                if (phase_reg == kehs_pkg::PH_KEY1)
                                begin
                                    phase_next = kehs_pkg::PH_ACK1;
                                    burst_load = 1'b1;
                                end
                                else
                                    phase_next = kehs_pkg::PH_ACK2;
                            end
                        end
                        kehs_pkg::PH_ACK1, kehs_pkg::PH_ACK2:
                        begin
                            timer_next = '0;
                            if (rx_reg == kehs_pkg::CHAR_C)
                            begin
                                phase_next = kehs_pkg::PH_KEY2;
                                idx_next   = '0;
                            end
                            else if (rx_reg == kehs_pkg::CHAR_A)
                            begin
                                phase_next      = kehs_pkg::PH_DONE;
                                burst_load      = 1'b1;
                                burst_kind_next = kehs_pkg::KIND_DONE;
                            end
                        end
                        kehs_pkg::PH_DONE:
                        begin
                        end
                        default:
                        begin
                            // listening
                            if (rx_reg == kehs_pkg::CHAR_C)
                            begin
                                phase_next = kehs_pkg::PH_KEY1;
                                idx_next   = '0;
                                timer_next = '0;
                            end
                        end
                    endcase
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= kehs_pkg::PH_LISTEN;
            idx_reg   <= '0;
            key_reg   <= '0;
            timer_reg <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            key_reg   <= key_next;
            timer_reg <= timer_next;
        end
    end

    // Result register: one burst of results at a time
    logic                          burst_active_reg, burst_active_next;
    logic [2:0]                    burst_idx_reg, burst_idx_next;
    logic                          burst_kind_reg;
    logic [kehs_pkg::KEY_BITS-1:0] burst_key_reg;
    logic                          burst_last;

    assign burst_last   = (burst_kind_reg == kehs_pkg::KIND_DONE) ||
                          (burst_idx_reg == kehs_pkg::TX_LAST_IDX);
    assign emitter_free = !burst_active_reg || (burst_last && !out_stall);

    always_comb
    begin
        burst_active_next = burst_active_reg;
        burst_idx_next    = burst_idx_reg;
        if (burst_load)
        begin
            burst_active_next = 1'b1;
            burst_idx_next    = '0;
        end
        else if (burst_active_reg && !out_stall)
        begin
            if (burst_last)
                burst_active_next = 1'b0;
            else
                burst_idx_next = burst_idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            burst_active_reg <= 1'b0;
            burst_idx_reg    <= '0;
        end
        else
        begin
            burst_active_reg <= burst_active_next;
            burst_idx_reg    <= burst_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_load)
        begin
            burst_kind_reg <= burst_kind_next;
            burst_key_reg  <= key_reg;
        end
    end

    // Result fields
    assign out_valid = burst_active_reg;
    assign kind      = burst_kind_reg;
    assign last      = burst_last;

    always_comb
    begin
        tx_byte    = '0;
        client_key = '0;
        if (burst_kind_reg == kehs_pkg::KIND_DONE)
            client_key = burst_key_reg;
        else
        begin
            unique case (burst_idx_reg)
                3'd0:    tx_byte = kehs_pkg::CHAR_A;
                3'd1:    tx_byte = server_key_reg[7:0];
                3'd2:    tx_byte = server_key_reg[15:8];
                3'd3:    tx_byte = server_key_reg[23:16];
                3'd4:    tx_byte = server_key_reg[31:24];
                default: tx_byte = '0;
            endcase
        end
    end

    // Assertions
    burst_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        burst_active_reg |-> (burst_idx_reg <= kehs_pkg::TX_LAST_IDX))
        else $error("transmit burst index out of range");

    done_is_single: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == kehs_pkg::KIND_DONE) |-> last)
        else $error("completion result not marked last");

    no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        burst_load |-> emitter_free)
        else $error("results loaded while previous burst still pending");

    burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && last && !out_stall && !burst_load) |=> !out_valid)
        else $error("result still valid after final transaction taken");

    done_reports_key: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_next == kehs_pkg::PH_DONE && phase_reg != kehs_pkg::PH_DONE)
        |-> (burst_load && burst_kind_next == kehs_pkg::KIND_DONE))
        else $error("handshake completed without reporting the client key");

endmodule

[verif/key_exchange_handshake_server_unit_tb.sv]
`timescale 1ns / 1ps

module key_exchange_handshake_server_unit_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 12;
    localparam int PHASE_ITEMS  = 30;

    // One result transaction as seen on the result channel
    typedef struct packed {
        logic                          kind;
        logic [7:0]                    tx_byte;
        logic [kehs_pkg::KEY_BITS-1:0] client_key;
        logic                          last;
    } hs_result_t;

    // Handshake predictor plus queue of results still owed by the block
    class handshake_scoreboard;
        kehs_pkg::phase_t                  ph;
        logic [1:0]                        key_count;
        logic [kehs_pkg::KEY_BITS-1:0]     key_sr;
        logic [kehs_pkg::TIMER_BITS-1:0]   wait_cnt;
        logic [kehs_pkg::KEY_BITS-1:0]     srv_key;
        logic [kehs_pkg::TIMEOUT_BITS-1:0] timeout;
        hs_result_t                        owed_q[$];
        int                                fail_count;

        function new();
            srv_key    = kehs_pkg::SERVER_KEY_RESET;
            timeout    = kehs_pkg::TIMEOUT_RESET;
            fail_count = 0;
            back_to_listen();
        endfunction

        function void back_to_listen();
            ph        = kehs_pkg::PH_LISTEN;
            key_count = '0;
            key_sr    = '0;
            wait_cnt  = '0;
        endfunction

        function int pending();
            return owed_q.size();
        endfunction

        // shift one key byte in, LSB first; returns 1 once four are in
        function bit shift_key_byte(input logic [7:0] b);
            key_sr    = {b, key_sr[kehs_pkg::KEY_BITS-1:8]};
            key_count = key_count + 2'd1;
            return key_count == 2'd0;
        endfunction

        // Predict the results of one accepted input transaction
        function void note_input(input logic [1:0] m, input logic [7:0] b);
            hs_result_t burst[$];
            hs_result_t r;
            case (kehs_pkg::mode_t'(m))
                kehs_pkg::MODE_RESTART: back_to_listen();
                kehs_pkg::MODE_TICK:
                begin
                    if (ph != kehs_pkg::PH_LISTEN && ph != kehs_pkg::PH_DONE)
                    begin
                        if (wait_cnt != '1)
                            wait_cnt = wait_cnt + kehs_pkg::TIMER_BITS'(1);
                        if (kehs_pkg::CMP_BITS'(wait_cnt) >= kehs_pkg::CMP_BITS'(timeout))
                            back_to_listen();
                    end
                end
                kehs_pkg::MODE_BYTE:
                begin
                    case (ph)
                        kehs_pkg::PH_LISTEN:
                        begin
                            if (b == kehs_pkg::CHAR_C)
                            begin
                                ph        = kehs_pkg::PH_KEY1;
                                key_count = '0;
                                wait_cnt  = '0;
                            end
                        end
                        kehs_pkg::PH_KEY1:
                        begin
                            if (shift_key_byte(b))
                            begin
                                // acknowledge byte, then server key LSB first
                                r = '{kind: kehs_pkg::KIND_TX, tx_byte: kehs_pkg::CHAR_A,
                                      client_key: '0, last: 1'b0};
                                burst.push_back(r);
                                for (int i = 0; i < 4; i++)
                                begin
                                    r.tx_byte = srv_key[8*i +: 8];
                                    burst.push_back(r);
                                end
                                ph       = kehs_pkg::PH_ACK1;
                                wait_cnt = '0;
                            end
                        end
                        kehs_pkg::PH_KEY2:
                        begin
                            if (shift_key_byte(b))
                            begin
                                ph       = kehs_pkg::PH_ACK2;
                                wait_cnt = '0;
                            end
                        end
                        kehs_pkg::PH_ACK1, kehs_pkg::PH_ACK2:
                        begin
                            wait_cnt = '0;
                            if (b == kehs_pkg::CHAR_C)
                            begin
                                ph        = kehs_pkg::PH_KEY2;
                                key_count = '0;
                            end
                            else if (b == kehs_pkg::CHAR_A)
                            begin
                                r = '{kind: kehs_pkg::KIND_DONE, tx_byte: 8'h00,
                                      client_key: key_sr, last: 1'b0};
                                burst.push_back(r);
                                ph = kehs_pkg::PH_DONE;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
            if (burst.size() > 0)
                burst[burst.size()-1].last = 1'b1;
            foreach (burst[i])
                owed_q.push_back(burst[i]);
        endfunction

        // Compare one accepted result with the oldest owed result
        function void check_result(input logic k, input logic [7:0] t,
                                   input logic [kehs_pkg::KEY_BITS-1:0] ck, input logic l);
            hs_result_t e;
            if (owed_q.size() == 0)
            begin
                $error("result with none owed: kind %0d tx_byte %h client_key %h last %0d",
                       k, t, ck, l);
                fail_count++;
                return;
            end
            e = owed_q.pop_front();
            if (k !== e.kind)
            begin
                $error("kind mismatch: expected %0d actual %0d", e.kind, k);
                fail_count++;
            end
            if (t !== e.tx_byte)
            begin
                $error("tx_byte mismatch: expected %h actual %h", e.tx_byte, t);
                fail_count++;
            end
            if (ck !== e.client_key)
            begin
                $error("client_key mismatch: expected %h actual %h", e.client_key, ck);
                fail_count++;
            end
            if (l !== e.last)
            begin
                $error("last mismatch: expected %0d actual %0d", e.last, l);
                fail_count++;
            end
        endfunction
    endclass

    logic                           clk       = 1'b0;
    logic                           rst_n     = 1'b0;
    logic                           in_valid  = 1'b0;
    logic                           in_stall;
    logic [1:0]                     mode      = kehs_pkg::MODE_NONE;
    logic [7:0]                     rx_byte   = 8'h00;
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic                           kind;
    logic [7:0]                     tx_byte;
    logic [kehs_pkg::KEY_BITS-1:0]  client_key;
    logic                           last;
    logic                           psel      = 1'b0;
    logic                           penable   = 1'b0;
    logic                           pwrite    = 1'b0;
    logic [kehs_pkg::ADDR_BITS-1:0] paddr     = '0;
    logic [31:0]                    pwdata    = '0;
    logic [31:0]                    prdata;
    logic                           pready;

    handshake_scoreboard sb;
    int send_idle_pct = 0;
    int stall_pct     = 0;
    int items_sent    = 0;
    int cycle_count   = 0;

    key_exchange_handshake_server_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .tx_byte    (tx_byte),
        .client_key (client_key),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Monitor both channels at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_input(mode, rx_byte);
            if (out_valid && !out_stall)
                sb.check_result(kind, tx_byte, client_key, last);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("key_exchange_handshake_server_unit_tb: FAIL");
            $finish;
        end
    end

    // Present one input transaction and hold it until accepted
    task automatic send(input kehs_pkg::mode_t m, input logic [7:0] b);
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        mode     <= m;
        rx_byte  <= b;
        do
            @(posedge clk);
        while (in_stall);
        if (m != kehs_pkg::MODE_NONE)
            items_sent++;
    endtask

    // Stop sending and let the block drain completely
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic read_reg(input logic idx, input logic [31:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= kehs_pkg::ADDR_BITS'({idx, 2'b00});
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (prdata !== want)
        begin
            $error("register %0d readback mismatch: expected %h actual %h", idx, want, prdata);
            sb.fail_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= kehs_pkg::ADDR_BITS'({idx, 2'b00});
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == kehs_pkg::REG_SERVER_KEY)
            sb.srv_key = val;
        else
            sb.timeout = val[kehs_pkg::TIMEOUT_BITS-1:0];
    endtask

    // Idle the block, load both registers and read them back
    task automatic configure(input logic [31:0] key, input logic [15:0] tmo);
        settle();
        write_reg(kehs_pkg::REG_SERVER_KEY, key);
        write_reg(kehs_pkg::REG_TIMEOUT, 32'(tmo));
        read_reg(kehs_pkg::REG_SERVER_KEY, key);
        read_reg(kehs_pkg::REG_TIMEOUT, 32'(tmo));
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 3))
            0:       send(kehs_pkg::MODE_TICK, 8'($urandom));
            1:       send(kehs_pkg::MODE_NONE, 8'($urandom));
            default: send(kehs_pkg::MODE_BYTE, 8'($urandom));
        endcase
    endtask

    // Four key bytes with the odd tick or stray transaction between them
    task automatic send_key();
        for (int i = 0; i < 4; i++)
        begin
            if ($urandom_range(0, 99) < 15)
                send(kehs_pkg::MODE_TICK, 8'($urandom));
            if ($urandom_range(0, 99) < 3)
                send_noise();
            send(kehs_pkg::MODE_BYTE, 8'($urandom));
        end
    endtask

    // One handshake attempt: mostly well formed, sometimes broken
    task automatic run_session();
        if ($urandom_range(0, 99) < 25)
            send_noise();
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_C);
        send_key();
        case ($urandom_range(0, 9))
            0, 1:
            begin
                // replacement key before completing
                if ($urandom_range(0, 1))
                    send(kehs_pkg::MODE_TICK, 8'($urandom));
                send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_C);
                send_key();
                send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_A);
            end
            2:
            begin
                send_noise();
                send_noise();
                send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_A);
            end
            3:
            begin
                // left hanging; ticks may time it out
                repeat ($urandom_range(1, 4)) send(kehs_pkg::MODE_TICK, 8'($urandom));
            end
            4:
                send(kehs_pkg::MODE_RESTART, 8'($urandom));
            default:
                send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_A);
        endcase
        // traffic after completion is ignored until restart
        if ($urandom_range(0, 99) < 30)
            send_noise();
        send(kehs_pkg::MODE_RESTART, 8'($urandom));
    endtask

    task automatic run_phase(input int idle, input int stall);
        logic [15:0] tmo;
        case ($urandom_range(0, 5))
            0:       tmo = 16'hFFFF;
            1:       tmo = kehs_pkg::TIMEOUT_RESET;
            default: tmo = 16'($urandom_range(1, 8));
        endcase
        configure($urandom, tmo);
        send_idle_pct = idle;
        stall_pct     = stall;
        items_sent    = 0;
        while (items_sent < PHASE_ITEMS)
            run_session();
    endtask

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset values, then directed traffic with the reset key
        read_reg(kehs_pkg::REG_SERVER_KEY, 32'(kehs_pkg::SERVER_KEY_RESET));
        read_reg(kehs_pkg::REG_TIMEOUT, 32'(kehs_pkg::TIMEOUT_RESET));
        send(kehs_pkg::MODE_NONE, 8'hFF);
        send(kehs_pkg::MODE_TICK, 8'h00);
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_A);
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_C);
        send(kehs_pkg::MODE_BYTE, 8'h00);
        send(kehs_pkg::MODE_BYTE, 8'hFF);
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_A);
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_C);
        send(kehs_pkg::MODE_TICK, 8'hAA);
        send(kehs_pkg::MODE_BYTE, 8'h55);
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_C);
        send(kehs_pkg::MODE_BYTE, 8'h80);
        send(kehs_pkg::MODE_BYTE, 8'h01);
        send(kehs_pkg::MODE_BYTE, 8'h7F);
        send(kehs_pkg::MODE_BYTE, 8'hFE);
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_A);
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_C);
        send(kehs_pkg::MODE_TICK, 8'h00);
        send(kehs_pkg::MODE_RESTART, 8'hFF);

        // Shortest timeout: first tick in a wait drops back to listen
        configure(32'hFFFF_FFFF, 16'd1);
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_C);
        send(kehs_pkg::MODE_TICK, 8'h00);
        send(kehs_pkg::MODE_BYTE, 8'h12);
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_C);
        repeat (4) send(kehs_pkg::MODE_BYTE, 8'hC3);
        send(kehs_pkg::MODE_TICK, 8'h00);
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_A);

        // Zero timeout behaves the same way
        configure(32'h0000_0000, 16'd0);
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_C);
        send(kehs_pkg::MODE_BYTE, 8'h3C);
        send(kehs_pkg::MODE_TICK, 8'h00);
        send(kehs_pkg::MODE_BYTE, 8'h3C);

        // Longest timeout; restart in the middle of a key
        configure(32'h1234_5678, 16'hFFFF);
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_C);
        send(kehs_pkg::MODE_BYTE, 8'h11);
        send(kehs_pkg::MODE_RESTART, 8'h00);
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_C);
        repeat (4) send(kehs_pkg::MODE_BYTE, 8'($urandom));
        send(kehs_pkg::MODE_TICK, 8'h00);
        send(kehs_pkg::MODE_BYTE, kehs_pkg::CHAR_A);
        send(kehs_pkg::MODE_RESTART, 8'h00);

        // Random sessions under each idling pattern
        run_phase(0, 0);
        run_phase(84, 0);
        run_phase(0, 84);
        run_phase(17, 17);

        settle();
        if (sb.pending() != 0)
        begin
            $error("%0d results never arrived", sb.pending());
            sb.fail_count++;
        end
        if (sb.fail_count == 0)
            $display("key_exchange_handshake_server_unit_tb: PASS");
        else
            $display("key_exchange_handshake_server_unit_tb: FAIL");
        $finish;
    end

endmodule
